// File: rtl/core/tkh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Top-k min-heap selector package
// Shared types and constants of the top-k selection block.
// ----------------------------------------------------------------------------
package tkh_pkg;

    localparam int SAMPLE_W = 32;
    localparam int KEEP_W   = 6;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [KEEP_W-1:0]          t_keep;

    localparam t_keep KEEP_RESET = 6'd5;

endpackage : tkh_pkg
`default_nettype wire

// File: rtl/core/tkh_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Heap storage
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module tkh_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire tkh_pkg::t_sample i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output tkh_pkg::t_sample      o_rdata
);
    import tkh_pkg::*;

    t_sample r_mem [DEPTH];
    t_sample r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule : tkh_ram
`default_nettype wire

// File: rtl/core/tkh_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Heap sequencer
// Runs sift-up, sift-down and the drain over the heap memory with one shared
// signed comparator, and holds the result register of the output stream.
// ----------------------------------------------------------------------------
module tkh_ctrl #(
    parameter int AW       = 5,
    parameter int FW       = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_clear,
    input  wire logic [FW-1:0]    i_keep,
    input  wire logic             i_s_valid,
    output logic                  o_s_ready,
    input  wire tkh_pkg::t_sample i_sample,
    input  wire logic             i_eos,
    output logic                  o_m_valid,
    input  wire logic             i_m_ready,
    output tkh_pkg::t_sample      o_m_data,
    output logic                  o_m_last,
    output logic                  o_we,
    output logic [AW-1:0]         o_waddr,
    output tkh_pkg::t_sample      o_wdata,
    output logic                  o_re,
    output logic [AW-1:0]         o_raddr,
    input  wire tkh_pkg::t_sample i_rdata
);
    import tkh_pkg::*;

    localparam int CW = AW + 1;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_UP_CHK   = 4'd1;
    localparam logic [3:0] ST_UP_CMP   = 4'd2;
    localparam logic [3:0] ST_TOP_WAIT = 4'd3;
    localparam logic [3:0] ST_DN_CHK   = 4'd4;
    localparam logic [3:0] ST_DN_L     = 4'd5;
    localparam logic [3:0] ST_DN_R     = 4'd6;
    localparam logic [3:0] ST_DN_MV    = 4'd7;
    localparam logic [3:0] ST_DR_RD    = 4'd8;
    localparam logic [3:0] ST_DR_TOP   = 4'd9;
    localparam logic [3:0] ST_DR_LAST  = 4'd10;

    logic [3:0]    r_state, n_state;
    logic [FW-1:0] r_fill,  n_fill;
    logic [FW-1:0] r_len,   n_len;
    logic [AW-1:0] r_pos,   n_pos;
    logic [AW-1:0] r_child, n_child;
    t_sample       r_moving, n_moving;
    t_sample       r_cval,   n_cval;
    logic          r_last,   n_last;
    logic          r_mvalid, n_mvalid;
    t_sample       r_mdata,  n_mdata;
    logic          r_mlast,  n_mlast;

    t_sample       w_cmp_a;
    t_sample       w_cmp_b;
    logic          w_lt;
    logic [AW-1:0] w_parent;
    logic [CW-1:0] w_left;
    logic [CW-1:0] w_right;
    logic [3:0]    w_done_state;

    // The one comparator of the block, shared by every step of the sequencer.
    always_comb begin
        unique case (r_state)
            ST_TOP_WAIT: begin
                w_cmp_a = i_rdata;
                w_cmp_b = r_moving;
            end
            ST_DN_R: begin
                w_cmp_a = i_rdata;
                w_cmp_b = r_cval;
            end
            ST_DN_MV: begin
                w_cmp_a = r_cval;
                w_cmp_b = r_moving;
            end
            default: begin
                w_cmp_a = r_moving;
                w_cmp_b = i_rdata;
            end
        endcase
    end

    assign w_lt         = (w_cmp_a < w_cmp_b);
    assign w_parent     = (r_pos - AW'(1)) >> 1;
    assign w_left       = {r_pos, 1'b1};
    assign w_right      = CW'(r_child) + CW'(1);
    assign w_done_state = r_last ? ST_DR_RD : ST_IDLE;

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_len    = r_len;
        n_pos    = r_pos;
        n_child  = r_child;
        n_moving = r_moving;
        n_cval   = r_cval;
        n_last   = r_last;
        n_mvalid = r_mvalid;
        n_mdata  = r_mdata;
        n_mlast  = r_mlast;
        o_we     = 1'b0;
        o_waddr  = r_pos;
        o_wdata  = r_moving;
        o_re     = 1'b0;
        o_raddr  = '0;

        if (r_mvalid && i_m_ready) begin
            n_mvalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    n_moving = i_sample;
                    n_last   = i_eos;
                    if (r_fill < i_keep) begin
                        n_pos   = AW'(r_fill);
                        n_fill  = r_fill + FW'(1);
                        n_state = ST_UP_CHK;
                    end else begin
                        o_re    = 1'b1;
                        n_len   = r_fill;
                        n_state = ST_TOP_WAIT;
                    end
                end
            end
            ST_UP_CHK: begin
                if (r_pos == '0) begin
                    o_we    = 1'b1;
                    n_state = w_done_state;
                end else begin
                    o_re    = 1'b1;
                    o_raddr = w_parent;
                    n_state = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                o_we = 1'b1;
                if (w_lt) begin
                    o_wdata = i_rdata;
                    n_pos   = w_parent;
                    n_state = ST_UP_CHK;
                end else begin
                    n_state = w_done_state;
                end
            end
            ST_TOP_WAIT: begin
                if (w_lt) begin
                    n_pos   = '0;
                    n_state = ST_DN_CHK;
                end else begin
                    n_state = w_done_state;
                end
            end
            ST_DN_CHK: begin
                if (w_left >= CW'(r_len)) begin
                    o_we    = 1'b1;
                    n_state = w_done_state;
                end else begin
                    o_re    = 1'b1;
                    o_raddr = AW'(w_left);
                    n_child = AW'(w_left);
                    n_state = ST_DN_L;
                end
            end
            ST_DN_L: begin
                n_cval = i_rdata;
                if (w_right < CW'(r_len)) begin
                    o_re    = 1'b1;
                    o_raddr = AW'(w_right);
                    n_state = ST_DN_R;
                end else begin
                    n_state = ST_DN_MV;
                end
            end
            ST_DN_R: begin
                if (w_lt) begin
                    n_cval  = i_rdata;
                    n_child = AW'(w_right);
                end
                n_state = ST_DN_MV;
            end
            ST_DN_MV: begin
                o_we = 1'b1;
                if (w_lt) begin
                    o_wdata = r_cval;
                    n_pos   = r_child;
                    n_state = ST_DN_CHK;
                end else begin
                    n_state = w_done_state;
                end
            end
            ST_DR_RD: begin
                if (r_fill == '0) begin
                    n_last  = 1'b0;
                    n_state = ST_IDLE;
                end else begin
                    o_re    = 1'b1;
                    n_state = ST_DR_TOP;
                end
            end
            ST_DR_TOP: begin
                if (!r_mvalid || i_m_ready) begin
                    n_mvalid = 1'b1;
                    n_mdata  = i_rdata;
                    n_mlast  = (r_fill == FW'(1));
                    n_fill   = r_fill - FW'(1);
                    if (r_fill != FW'(1)) begin
                        o_re    = 1'b1;
                        o_raddr = AW'(r_fill - FW'(1));
                        n_len   = r_fill - FW'(1);
                        n_state = ST_DR_LAST;
                    end else begin
                        n_state = ST_DR_RD;
                    end
                end
            end
            ST_DR_LAST: begin
                n_moving = i_rdata;
                n_pos    = '0;
                n_state  = ST_DN_CHK;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_clear) begin
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= '0;
            r_last   <= 1'b0;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_last   <= n_last;
            r_mvalid <= n_mvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_pos    <= n_pos;
        r_child  <= n_child;
        r_moving <= n_moving;
        r_cval   <= n_cval;
        r_mdata  <= n_mdata;
        r_mlast  <= n_mlast;
    end

    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_mvalid;
    assign o_m_data  = r_mdata;
    assign o_m_last  = r_mlast;

    a_fill_within_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= i_keep)
        else $error("Heap fill count exceeds the keep count.");

    a_idle_not_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_last)
        else $error("Sequencer is idle with a drain still pending.");

    a_drain_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DR_TOP && (!r_mvalid || i_m_ready)) |=> r_mvalid)
        else $error("Drain step did not present a result.");

    a_sift_pos_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DN_CHK) |-> (FW'(r_pos) < r_len))
        else $error("Sift-down position lies outside the heap.");

endmodule : tkh_ctrl
`default_nettype wire

// File: rtl/core/top_k_min_heap_select.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Top-k min-heap selector
// Keeps the k largest signed samples of a stream in a binary min-heap and
// drains them in ascending order when the last sample of the stream arrives.
// ----------------------------------------------------------------------------
// One sample is taken at a time and the input stays not ready while the heap
// is updated. All heap work goes through a heap memory with a registered read
// and one shared signed comparator, so the cost is set by the memory reads: a
// fill insert reads one parent per heap level climbed, a replacement of the
// heap top reads the top and then sifts down from the root, a dropped sample
// reads only the top, and each drained value sifts the last entry down from
// the root, plus any wait for the output side to take the previous transfer.
// Writing keep_count empties the heap.
// ----------------------------------------------------------------------------
module top_k_min_heap_select #(
    parameter int CAPACITY = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire tkh_pkg::t_keep   i_cfg_wdata,     // keep_count
    input  wire logic             i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  wire tkh_pkg::t_sample i_s_axis_tdata,  // [31:0] sample_value
    input  wire logic             i_s_axis_tlast,  // end_of_stream
    output logic                  o_m_axis_tvalid,
    input  wire logic             i_m_axis_tready,
    output tkh_pkg::t_sample      o_m_axis_tdata,  // [31:0] kept_value
    output logic                  o_m_axis_tlast   // run_last
);
    import tkh_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);

    t_keep         r_keep;
    logic [FW-1:0] w_keep_eff;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_sample       w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    t_sample       w_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= KEEP_RESET;
        end else if (i_cfg_we) begin
            r_keep <= i_cfg_wdata;
        end
    end

    // A keep count of zero acts as one, and counts past the heap size saturate.
    always_comb begin
        priority if (r_keep == '0) begin
            w_keep_eff = FW'(1);
        end else if ({1'b0, r_keep} > (KEEP_W + 1)'(CAPACITY)) begin
            w_keep_eff = FW'(CAPACITY);
        end else begin
            w_keep_eff = FW'(r_keep);
        end
    end

    tkh_ctrl #(
        .AW       (AW),
        .FW       (FW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (i_cfg_we),
        .i_keep    (w_keep_eff),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_sample  (i_s_axis_tdata),
        .i_eos     (i_s_axis_tlast),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_m_data  (o_m_axis_tdata),
        .o_m_last  (o_m_axis_tlast),
        .o_we      (w_we),
        .o_waddr   (w_waddr),
        .o_wdata   (w_wdata),
        .o_re      (w_re),
        .o_raddr   (w_raddr),
        .i_rdata   (w_rdata)
    );

    tkh_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

endmodule : top_k_min_heap_select
`default_nettype wire

// File: test/top_k_min_heap_select_tb.sv
// ----------------------------------------------------------------------------
// Top-k min-heap selector testbench
// Feeds streams of signed samples through the selector under several
// keep_count settings and checks every drained value and its tlast flag
// against a sorted-list predictor kept alongside the block. A directed table
// covers the extremes and the corner cases, and random streams follow.
// Both stream sides idle at random, and one phase runs without idling. The
// receiver holds off once for a long stretch, and in one phase the sender
// waits for each drain to finish.
// ----------------------------------------------------------------------------
module top_k_min_heap_select_tb;

    import tkh_pkg::*;

    localparam int          CAPACITY      = 32;
    localparam int          RESET_CYCLES  = 11;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          HOLD_CYCLES   = 300;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam t_sample SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

    typedef enum logic {ROW_ITEM, ROW_KEEP} t_row_kind;

    typedef struct packed {
        t_row_kind kind;
        t_keep     keep;
        t_sample   sample;
        logic      last;
        logic      typed;
        t_sample   typed_value;
    } t_stim_row;

    typedef struct packed {
        t_sample value;
        logic    last;
    } t_kept;

    localparam t_stim_row DIRECTED_ROWS [26] = '{
        '{ROW_ITEM, 6'd0,  32'sd7,     1'b1, 1'b1, 32'sd7},
        '{ROW_ITEM, 6'd0,  -32'sd3,    1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 6'd0,  32'sd100,   1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 6'd0,  32'sd42,    1'b1, 1'b0, 32'sd0},
        '{ROW_KEEP, 6'd1,  32'sd0,     1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 6'd0,  SAMPLE_MIN, 1'b1, 1'b1, SAMPLE_MIN},
        '{ROW_ITEM, 6'd0,  SAMPLE_MAX, 1'b1, 1'b1, SAMPLE_MAX},
        '{ROW_ITEM, 6'd0,  32'sd5,     1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 6'd0,  32'sd9,     1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 6'd0,  32'sd9,     1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 6'd0,  32'sd2,     1'b1, 1'b1, 32'sd9},
        '{ROW_KEEP, 6'd0,  32'sd0,     1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 6'd0,  -32'sd1,    1'b1, 1'b1, -32'sd1},
        '{ROW_KEEP, 6'd3,  32'sd0,     1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 6'd0,  32'sd10,    1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 6'd0,  32'sd20,    1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 6'd0,  32'sd30,    1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 6'd0,  32'sd30,    1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 6'd0,  32'sd20,    1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 6'd0,  32'sd5,     1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 6'd0,  32'sd40,    1'b1, 1'b0, 32'sd0},
        '{ROW_ITEM, 6'd0,  32'sd11,    1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 6'd0,  32'sd12,    1'b0, 1'b0, 32'sd0},
        '{ROW_KEEP, 6'd2,  32'sd0,     1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 6'd0,  SAMPLE_MIN, 1'b0, 1'b0, 32'sd0},
        '{ROW_ITEM, 6'd0,  SAMPLE_MAX, 1'b1, 1'b0, 32'sd0}
    };

    localparam t_keep   PHASE_KEEP  [7] = '{6'd63, 6'd32, 6'd7, 6'd4, 6'd1, 6'd16, 6'd33};
    localparam int      PHASE_ITEMS [7] = '{40, 40, 25, 25, 20, 25, 35};
    localparam t_sample EDGE_SAMPLES [4] = '{SAMPLE_MIN, SAMPLE_MAX, 32'sd0, -32'sd1};

    logic    i_clk;
    logic    i_rst_n          = 1'b0;
    logic    i_cfg_we         = 1'b0;
    t_keep   i_cfg_wdata      = '0;
    logic    i_s_axis_tvalid  = 1'b0;
    logic    o_s_axis_tready;
    t_sample i_s_axis_tdata   = '0;   // [31:0] sample_value
    logic    i_s_axis_tlast   = 1'b0; // end_of_stream
    logic    o_m_axis_tvalid;
    logic    i_m_axis_tready  = 1'b0;
    t_sample o_m_axis_tdata;          // [31:0] kept_value
    logic    o_m_axis_tlast;          // run_last

    // Travels with the sample on the bus so that the accepting edge sees it.
    logic    item_typed       = 1'b0;
    t_sample item_typed_value = '0;

    t_keep   keep_reg = KEEP_RESET;
    t_sample kept_vals[$];
    t_kept   drain_out[$];
    t_kept   kept_expected[$];

    int unsigned cycle_count   = 0;
    int unsigned mismatches    = 0;
    int unsigned items_taken   = 0;
    int unsigned streams_taken = 0;
    int unsigned results_seen  = 0;
    int unsigned keep_writes   = 0;
    int unsigned hold_asked    = 0;
    int unsigned hold_done     = 0;
    int unsigned hold_left     = 0;
    bit          send_jitter   = 1'b1;
    bit          recv_jitter   = 1'b1;

    top_k_min_heap_select #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned effective_keep(input t_keep kv);
        if (kv == '0) return 1;
        if (kv > CAPACITY) return CAPACITY;
        return kv;
    endfunction

    // The kept values are held in ascending order, so the drain is a plain walk.
    function automatic void absorb_sample(input t_sample v, input logic last);
        int unsigned kk;
        int unsigned pos;
        t_kept       r;
        kk = effective_keep(keep_reg);
        drain_out.delete();
        if (kept_vals.size() < kk || v > kept_vals[0]) begin
            if (kept_vals.size() >= kk) begin
                void'(kept_vals.pop_front());
            end
            pos = 0;
            while (pos < kept_vals.size() && kept_vals[pos] <= v) pos++;
            kept_vals.insert(pos, v);
        end
        if (last) begin
            for (int i = 0; i < kept_vals.size(); i++) begin
                r.value = kept_vals[i];
                r.last  = (i == kept_vals.size() - 1);
                drain_out = {drain_out, r};
            end
            kept_vals.delete();
        end
    endfunction

    function automatic t_sample pick_sample();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel == 0) return EDGE_SAMPLES[$urandom_range(3)];
        if (sel < 4) return t_sample'(int'($urandom_range(15)) - 8);
        return t_sample'($urandom);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (kept_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_keep(input t_keep kv);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= kv;
        keep_reg = kv;
        kept_vals.delete();
        keep_writes++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic offer_sample(input t_sample v, input logic last,
                                input logic typed, input t_sample typed_v);
        while (send_jitter && $urandom_range(99) < 37) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid  <= 1'b1;
        i_s_axis_tdata   <= v;
        i_s_axis_tlast   <= last;
        item_typed       <= typed;
        item_typed_value <= typed_v;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : input_side
        t_kept r;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            absorb_sample(i_s_axis_tdata, i_s_axis_tlast);
            if (item_typed) begin
                r.value = item_typed_value;
                r.last  = 1'b1;
                kept_expected = {kept_expected, r};
            end else begin
                foreach (drain_out[i]) kept_expected = {kept_expected, drain_out[i]};
            end
            items_taken++;
            if (i_s_axis_tlast) streams_taken++;
        end
    end

    always @(posedge i_clk) begin : output_side
        t_kept want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (kept_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected kept_value %0d", o_m_axis_tdata));
            end else begin
                want = kept_expected.pop_front();
                if (o_m_axis_tdata !== want.value) begin
                    report_mismatch($sformatf("kept_value %0d, expected %0d",
                                              o_m_axis_tdata, want.value));
                end
                if (o_m_axis_tlast !== want.last) begin
                    report_mismatch($sformatf("run_last %b, expected %b on value %0d",
                                              o_m_axis_tlast, want.last, want.value));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_done != hold_asked) begin
            hold_done       <= hold_asked;
            hold_left       <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (recv_jitter) begin
            i_m_axis_tready <= ($urandom_range(99) >= 37);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, kept_expected.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned budget;
        int unsigned len;
        int unsigned kk;
        bit          first;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[n]) begin
            if (DIRECTED_ROWS[n].kind == ROW_KEEP) begin
                write_keep(DIRECTED_ROWS[n].keep);
            end else begin
                offer_sample(DIRECTED_ROWS[n].sample, DIRECTED_ROWS[n].last,
                             DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].typed_value);
            end
        end

        // Phase 1 runs without idling, phase 3 stalls the receiver after its
        // first stream, and phase 4 lets every drain finish before going on.
        for (int p = 0; p < 7; p++) begin
            write_keep(PHASE_KEEP[p]);
            send_jitter = (p != 1);
            recv_jitter = (p != 1);
            kk     = effective_keep(PHASE_KEEP[p]);
            budget = PHASE_ITEMS[p];
            first  = 1'b1;
            while (budget > 0) begin
                len = first ? kk + 2 : $urandom_range(1, kk + 8);
                if (len > budget) len = budget;
                for (int i = 0; i < len; i++) begin
                    offer_sample(pick_sample(), (i == len - 1), 1'b0, '0);
                end
                budget -= len;
                if (p == 3 && first) hold_asked <= hold_asked + 1;
                if (p == 4) wait_idle();
                first = 1'b0;
            end
        end

        wait_idle();
        $display("Sent %0d samples in %0d streams across %0d keep_count writes.",
                 items_taken, streams_taken, keep_writes);
        $display("Checked %0d drained values, ties, short streams and a long output stall.",
                 results_seen);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
